>>> hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, command codes and phase helpers for the byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Command codes on the request beat
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   // Last phase index of each primitive, and the ACK phase indices of a byte
   localparam logic [4:0] PH_LAST_START = 5'd3;
   localparam logic [4:0] PH_LAST_STOP  = 5'd2;
   localparam logic [4:0] PH_LAST_BYTE  = 5'd18;
   localparam logic [4:0] PH_ACK_LOW    = 5'd16;
   localparam logic [4:0] PH_ACK_HIGH   = 5'd17;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd5;

   // Active primitive, one-hot
   typedef enum logic [4:0] {
      OP_IDLE  = 5'b00001,
      OP_START = 5'b00010,
      OP_STOP  = 5'b00100,
      OP_WRITE = 5'b01000,
      OP_READ  = 5'b10000
   } op_type;

   // Classified request beat, as queued between front and back
   typedef struct packed {
      op_type     op;
      logic       cmd_nonzero;
      logic [7:0] tx_byte;
      logic       nack_after_read;
      logic       sda_level;
   } item_type;

   // Bus drive pair
   typedef struct packed {
      logic scl;
      logic sda;
   } drive_type;

   // Result beat fields
   typedef struct packed {
      logic       cmd_rejected;
      logic [7:0] rx_byte;
      logic       ack_seen;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } result_type;

   // Map a command code to a primitive; unknown codes mean no primitive
   function automatic op_type decode_cmd(input logic [2:0] cmd);
      op_type op;
      case (cmd)
         CMD_START: op = OP_START;
         CMD_STOP:  op = OP_STOP;
         CMD_WRITE: op = OP_WRITE;
         CMD_READ:  op = OP_READ;
         default:   op = OP_IDLE;
      endcase
      return op;
   endfunction

   function automatic logic [4:0] last_phase(input op_type op);
      logic [4:0] ph;
      case (op)
         OP_START: ph = PH_LAST_START;
         OP_STOP:  ph = PH_LAST_STOP;
         default:  ph = PH_LAST_BYTE;
      endcase
      return ph;
   endfunction

   // Drive levels of the phase that begins now
   function automatic drive_type enter_phase(input op_type op, input logic [4:0] ph,
                                             input logic [7:0] shift, input logic nack,
                                             input drive_type cur);
      drive_type  drv;
      logic [2:0] bit_idx;
      drv     = cur;
      bit_idx = 3'd7 - ph[3:1];
      case (op)
         OP_START: begin
            case (ph[1:0])
               2'd0:    drv.sda = 1'b1;
               2'd1:    drv.scl = 1'b1;
               2'd2:    drv.sda = 1'b0;
               default: drv.scl = 1'b0;
            endcase
         end
         OP_STOP: begin
            case (ph[1:0])
               2'd0:    drv.sda = 1'b0;
               2'd1:    drv.scl = 1'b1;
               default: drv.sda = 1'b1;
            endcase
         end
         OP_WRITE, OP_READ: begin
            if (!ph[4]) begin
               if (!ph[0]) begin
                  drv.scl = 1'b0;
                  drv.sda = (op == OP_WRITE) ? shift[bit_idx] : 1'b1;
               end else begin
                  drv.scl = 1'b1;
               end
            end else if (ph == PH_ACK_LOW) begin
               drv.scl = 1'b0;
               drv.sda = (op == OP_WRITE) ? 1'b1 : nack;
            end else if (ph == PH_ACK_HIGH) begin
               drv.scl = 1'b1;
            end else begin
               drv.scl = 1'b0;
            end
         end
         default: drv = cur;
      endcase
      return drv;
   endfunction

endpackage

>>> hdl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Start, stop, write-byte and read-byte bus primitives, one beat per tick.
// ----------------------------------------------------------------------------
// Each request beat is one bus tick and returns exactly one response beat
// with the SCL/SDA drive for that tick and the engine status. The engine
// takes one beat per clock while the response side is not stalled: the
// whole phase update for a tick is done combinationally, and a request
// passes through the front queue entry and then the response register. A
// two-entry queue between the decoder and the engine lets request and
// response sides stall independently. Write phase_ticks over the csr port
// only while no beat is in flight.
module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command, [10:3] tx_byte, [11] nack_after_read, [12] sda_level
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_seen,
   // [12:5] rx_byte, [13] cmd_rejected
   output logic [15:0] rsp_tdata
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> hdl/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts request beats, decodes the command and queues them for the engine.
// ----------------------------------------------------------------------------
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command, [10:3] tx_byte, [11] nack_after_read, [12] sda_level
   input  logic [15:0] req_tdata,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_c;

   // Classify the incoming beat
   always_comb begin
      item_c.op              = decode_cmd(req_tdata[2:0]);
      item_c.cmd_nonzero     = (req_tdata[2:0] != CMD_NONE);
      item_c.tx_byte         = req_tdata[10:3];
      item_c.nack_after_read = req_tdata[11];
      item_c.sda_level       = req_tdata[12];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_c;
      end
   end

endmodule

>>> hdl/i2cm_back.sv
// ----------------------------------------------------------------------------
// I2C master engine
// Steps the bus phase sequencer once per queued tick and registers the result.
// ----------------------------------------------------------------------------
module i2cm_back
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [4] ack_seen,
   // [12:5] rx_byte, [13] cmd_rejected
   output logic [15:0] rsp_tdata
);

   logic [7:0] phase_ticks_ff;
   op_type     op_ff, op_in;
   logic [4:0] phase_ff, phase_in;
   logic [7:0] hold_ff, hold_in;
   logic [7:0] shift_ff, shift_in;
   drive_type  drive_ff, drive_in;
   logic       ack_ff, ack_in;
   logic [7:0] rx_ff, rx_in;
   logic       nack_ff, nack_in;
   logic       rsp_valid_ff;
   result_type res_ff, res_in;
   logic [7:0] limit;
   logic [8:0] hold_next;

   assign limit      = (phase_ticks_ff == 8'd0) ? 8'd1 : phase_ticks_ff;
   assign q_pop      = q_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, res_ff};

   // Step the engine for one tick
   always_comb begin
      op_in     = op_ff;
      phase_in  = phase_ff;
      hold_in   = hold_ff;
      shift_in  = shift_ff;
      drive_in  = drive_ff;
      ack_in    = ack_ff;
      rx_in     = rx_ff;
      nack_in   = nack_ff;
      res_in    = '0;
      hold_next = 9'd0;

      // Take a new primitive or flag it
      if (op_ff != OP_IDLE) begin
         res_in.cmd_rejected = q_item.cmd_nonzero;
      end else if (q_item.op != OP_IDLE) begin
         op_in    = q_item.op;
         phase_in = 5'd0;
         hold_in  = 8'd0;
         if (q_item.op == OP_WRITE) begin
            shift_in = q_item.tx_byte;
         end
         if (q_item.op == OP_READ) begin
            shift_in = 8'd0;
            nack_in  = q_item.nack_after_read;
         end
         drive_in = enter_phase(op_in, phase_in, shift_in, nack_in, drive_in);
      end

      res_in.scl_out = drive_in.scl;
      res_in.sda_out = drive_in.sda;

      // Count the hold and close the phase
      if (op_in != OP_IDLE) begin
         res_in.busy_res = 1'b1;
         hold_next       = {1'b0, hold_in} + 9'd1;
         hold_in         = hold_next[7:0];
         if (hold_next >= {1'b0, limit}) begin
            hold_in   = 8'd0;
            if (op_in == OP_WRITE && phase_in == PH_ACK_HIGH) begin
               ack_in = ~q_item.sda_level;
            end
            if (op_in == OP_READ && !phase_in[4] && phase_in[0]) begin
               shift_in = {shift_in[6:0], q_item.sda_level};
            end
            if (phase_in >= last_phase(op_in)) begin
               if (op_in == OP_READ) begin
                  rx_in = shift_in;
               end
               res_in.done_res = 1'b1;
               op_in           = OP_IDLE;
               phase_in        = 5'd0;
            end else begin
               phase_in = phase_in + 5'd1;
               drive_in = enter_phase(op_in, phase_in, shift_in, nack_in, drive_in);
            end
         end
      end

      res_in.ack_seen = ack_in;
      res_in.rx_byte  = rx_in;
   end

   // Hold the phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   // Update engine state on each consumed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_IDLE;
         phase_ff <= 5'd0;
         hold_ff  <= 8'd0;
         shift_ff <= 8'd0;
         drive_ff <= '{scl: 1'b1, sda: 1'b1};
         ack_ff   <= 1'b0;
         rx_ff    <= 8'd0;
         nack_ff  <= 1'b0;
      end else if (q_pop) begin
         op_ff    <= op_in;
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         shift_ff <= shift_in;
         drive_ff <= drive_in;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
         nack_ff  <= nack_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         res_ff <= res_in;
      end
   end

   // Engine checks
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.done_res |-> res_ff.busy_res)
      else $error("done beat without busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop && res_in.done_res |=> op_ff == OP_IDLE)
      else $error("engine not idle after done");

   // A shorter phase length may land mid-phase, so bound by the widest length
   a_hold_range: assert property (@(posedge clock) disable iff (reset)
      op_ff != OP_IDLE |-> hold_ff < 8'd255)
      else $error("hold count past phase length");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      op_ff != OP_IDLE |-> phase_ff <= last_phase(op_ff))
      else $error("phase index past last phase");

   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      op_ff == OP_IDLE |-> phase_ff == 5'd0)
      else $error("idle engine with nonzero phase");

endmodule
